### design/ecpu_pkg.sv
`timescale 1ns / 1ps
package ecpu_pkg;

  // Opcodes of the supported subset
  localparam logic [7:0] OPC_NOP       = 8'h00;
  localparam logic [7:0] OPC_LD_BC     = 8'h01;
  localparam logic [7:0] OPC_ST_BC_A   = 8'h02;
  localparam logic [7:0] OPC_INC_BC    = 8'h03;
  localparam logic [7:0] OPC_INC_B     = 8'h04;
  localparam logic [7:0] OPC_DEC_B     = 8'h05;
  localparam logic [7:0] OPC_LD_B      = 8'h06;
  localparam logic [7:0] OPC_RLCA      = 8'h07;
  localparam logic [7:0] OPC_ST_SP     = 8'h08;
  localparam logic [7:0] OPC_ADD_HL_BC = 8'h09;

  // Reset values of the architectural state
  localparam logic [7:0]  RST_A  = 8'h00;
  localparam logic [7:0]  RST_B  = 8'h00;
  localparam logic [7:0]  RST_C  = 8'h13;
  localparam logic [7:0]  RST_H  = 8'h01;
  localparam logic [7:0]  RST_L  = 8'h4D;
  localparam logic [15:0] RST_SP = 16'hFFFE;
  localparam logic [15:0] RST_PC = 16'h0100;
  localparam logic [3:0]  RST_F  = 4'h0;

  // Flag bit positions in the flag nibble
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Depth of the queue between decode and execute
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LD_BC,
    OP_ST_BC_A,
    OP_INC_BC,
    OP_INC_B,
    OP_DEC_B,
    OP_LD_B,
    OP_RLCA,
    OP_ST_SP,
    OP_ADD_HL_BC,
    OP_OTHER
  } op_kind_t;

  // Decoded instruction as it travels from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  len;
    logic [4:0]  cyc;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
  } decoded_t;

  // Queue head as seen by the execute side
  typedef struct packed {
    logic     valid;
    decoded_t item;
  } queue_head_t;

endpackage

### design/ecpu_front.sv
`timescale 1ns / 1ps
module ecpu_front (
  input  logic [7:0]         opcode,
  input  logic [7:0]         imm_low,
  input  logic [7:0]         imm_high,
  output ecpu_pkg::decoded_t decoded
);

  // Classify the opcode and attach its length and cycle cost
  always_comb begin
    decoded.imm_low  = imm_low;
    decoded.imm_high = imm_high;
    unique case (opcode)
      ecpu_pkg::OPC_NOP: begin
        decoded.kind = ecpu_pkg::OP_NOP;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd4;
      end
      ecpu_pkg::OPC_LD_BC: begin
        decoded.kind = ecpu_pkg::OP_LD_BC;
        decoded.len  = 2'd3;
        decoded.cyc  = 5'd12;
      end
      ecpu_pkg::OPC_ST_BC_A: begin
        decoded.kind = ecpu_pkg::OP_ST_BC_A;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd8;
      end
      ecpu_pkg::OPC_INC_BC: begin
        decoded.kind = ecpu_pkg::OP_INC_BC;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd8;
      end
      ecpu_pkg::OPC_INC_B: begin
        decoded.kind = ecpu_pkg::OP_INC_B;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd4;
      end
      ecpu_pkg::OPC_DEC_B: begin
        decoded.kind = ecpu_pkg::OP_DEC_B;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd4;
      end
      ecpu_pkg::OPC_LD_B: begin
        decoded.kind = ecpu_pkg::OP_LD_B;
        decoded.len  = 2'd2;
        decoded.cyc  = 5'd8;
      end
      ecpu_pkg::OPC_RLCA: begin
        decoded.kind = ecpu_pkg::OP_RLCA;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd4;
      end
      ecpu_pkg::OPC_ST_SP: begin
        decoded.kind = ecpu_pkg::OP_ST_SP;
        decoded.len  = 2'd3;
        decoded.cyc  = 5'd20;
      end
      ecpu_pkg::OPC_ADD_HL_BC: begin
        decoded.kind = ecpu_pkg::OP_ADD_HL_BC;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd8;
      end
      default: begin
        decoded.kind = ecpu_pkg::OP_OTHER;
        decoded.len  = 2'd1;
        decoded.cyc  = 5'd0;
      end
    endcase
  end

endmodule

### design/ecpu_queue.sv
`timescale 1ns / 1ps
module ecpu_queue #(
  parameter int DEPTH = ecpu_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ecpu_pkg::decoded_t    push_item,
  output logic                  full,
  input  logic                  pop,
  output ecpu_pkg::queue_head_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  ecpu_pkg::decoded_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_COUNT);
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/ecpu_back.sv
`timescale 1ns / 1ps
module ecpu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ecpu_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  write_valid,
  output logic [15:0]           write_address,
  output logic [7:0]            write_data,
  output logic                  last,
  output logic [15:0]           next_pc,
  output logic [31:0]           elapsed_cycles,
  output logic [7:0]            reg_a,
  output logic [7:0]            reg_b,
  output logic [7:0]            reg_c,
  output logic [7:0]            reg_h,
  output logic [7:0]            reg_l,
  output logic [3:0]            flag_bits
);

  // Architectural state
  logic [7:0]  acc;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [7:0]  h;
  logic [7:0]  l;
  logic [15:0] sp;
  logic [15:0] pc;
  logic [3:0]  flags;
  logic [31:0] cycles;
  logic        phase;

  logic [7:0]  acc_next;
  logic [7:0]  b_next;
  logic [7:0]  c_next;
  logic [7:0]  h_next;
  logic [7:0]  l_next;
  logic [15:0] pc_next;
  logic [3:0]  flags_next;
  logic [31:0] cycles_next;

  logic        wv;
  logic [15:0] waddr;
  logic [7:0]  wdata;
  logic        wlast;

  logic        load;
  logic        fire;
  logic        two_beat;
  logic [15:0] bc_inc;
  logic [16:0] hl_sum;
  logic [12:0] half_sum;
  logic [15:0] imm_addr;

  ecpu_pkg::decoded_t it;

  assign it       = head.item;
  assign load     = !out_valid || !out_stall;
  assign fire     = load && head.valid;
  assign two_beat = (it.kind == ecpu_pkg::OP_ST_SP);
  assign pop      = fire && (!two_beat || phase);

  assign bc_inc   = {b, c} + 16'd1;
  assign hl_sum   = {1'b0, h, l} + {1'b0, b, c};
  assign half_sum = {1'b0, h[3:0], l} + {1'b0, b[3:0], c};
  assign imm_addr = {it.imm_high, it.imm_low};

  // Compute the state after the instruction; second store beat changes nothing
  always_comb begin
    acc_next    = acc;
    b_next      = b;
    c_next      = c;
    h_next      = h;
    l_next      = l;
    flags_next  = flags;
    pc_next     = pc;
    cycles_next = cycles;
    if (!phase) begin
      pc_next     = pc + {14'd0, it.len};
      cycles_next = cycles + {27'd0, it.cyc};
      unique case (it.kind)
        ecpu_pkg::OP_LD_BC: begin
          c_next = it.imm_low;
          b_next = it.imm_high;
        end
        ecpu_pkg::OP_INC_BC: begin
          b_next = bc_inc[15:8];
          c_next = bc_inc[7:0];
        end
        ecpu_pkg::OP_INC_B: begin
          b_next = b + 8'd1;
          flags_next[ecpu_pkg::FLAG_Z] = (b == 8'hFF);
          flags_next[ecpu_pkg::FLAG_N] = 1'b0;
          flags_next[ecpu_pkg::FLAG_H] = (b[3:0] == 4'hF);
        end
        ecpu_pkg::OP_DEC_B: begin
          b_next = b - 8'd1;
          flags_next[ecpu_pkg::FLAG_Z] = (b == 8'h01);
          flags_next[ecpu_pkg::FLAG_N] = 1'b1;
          flags_next[ecpu_pkg::FLAG_H] = (b[3:0] == 4'h0);
        end
        ecpu_pkg::OP_LD_B: begin
          b_next = it.imm_low;
        end
        ecpu_pkg::OP_RLCA: begin
          acc_next   = {acc[6:0], acc[7]};
          flags_next = {3'b000, acc[7]};
        end
        ecpu_pkg::OP_ADD_HL_BC: begin
          h_next = hl_sum[15:8];
          l_next = hl_sum[7:0];
          flags_next[ecpu_pkg::FLAG_N] = 1'b0;
          flags_next[ecpu_pkg::FLAG_H] = half_sum[12];
          flags_next[ecpu_pkg::FLAG_C] = hl_sum[16];
        end
        default: begin
        end
      endcase
    end
  end

  // Form the write part of the result
  always_comb begin
    wv    = 1'b0;
    waddr = 16'd0;
    wdata = 8'd0;
    wlast = 1'b1;
    unique case (it.kind)
      ecpu_pkg::OP_ST_BC_A: begin
        wv    = 1'b1;
        waddr = {b, c};
        wdata = acc;
      end
      ecpu_pkg::OP_ST_SP: begin
        wv    = 1'b1;
        waddr = phase ? imm_addr + 16'd1 : imm_addr;
        wdata = phase ? sp[15:8] : sp[7:0];
        wlast = phase;
      end
      default: begin
      end
    endcase
  end

  // Commit state and track the store beat
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= ecpu_pkg::RST_A;
      b      <= ecpu_pkg::RST_B;
      c      <= ecpu_pkg::RST_C;
      h      <= ecpu_pkg::RST_H;
      l      <= ecpu_pkg::RST_L;
      sp     <= ecpu_pkg::RST_SP;
      pc     <= ecpu_pkg::RST_PC;
      flags  <= ecpu_pkg::RST_F;
      cycles <= '0;
      phase  <= 1'b0;
    end else if (fire) begin
      acc    <= acc_next;
      b      <= b_next;
      c      <= c_next;
      h      <= h_next;
      l      <= l_next;
      pc     <= pc_next;
      flags  <= flags_next;
      cycles <= cycles_next;
      phase  <= two_beat && !phase;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      write_valid    <= wv;
      write_address  <= waddr;
      write_data     <= wdata;
      last           <= wlast;
      next_pc        <= pc_next;
      elapsed_cycles <= cycles_next;
      reg_a          <= acc_next;
      reg_b          <= b_next;
      reg_c          <= c_next;
      reg_h          <= h_next;
      reg_l          <= l_next;
      flag_bits      <= flags_next;
    end
  end

endmodule

### design/eight_bit_cpu_opcode_subset_top.sv
`timescale 1ns / 1ps
// Executes opcodes 0x00-0x09 of an 8-bit handheld CPU, one fetched instruction
// (opcode plus the two bytes after it) per input item, and reports the register
// file, flags, PC and running cycle count after each instruction. Every
// instruction gives one result item, except LD (a16),SP, which gives two (low
// then high byte of SP); the final result of an instruction has last set.
// Unknown opcodes only advance PC by one. Items are decoded on entry and wait
// in a short queue (QUEUE_DEPTH entries) for the execute stage, which produces
// one result per cycle from its output register unless out_stall holds it or
// the queue is empty; LD (a16),SP yields its two results in turn. An item passes
// through the queue and then the output register before its result is presented.
module eight_bit_cpu_opcode_subset_top #(
  parameter int QUEUE_DEPTH = ecpu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opcode,
  input  logic [7:0]  imm_low,
  input  logic [7:0]  imm_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [15:0] write_address,
  output logic [7:0]  write_data,
  output logic        last,
  output logic [15:0] next_pc,
  output logic [31:0] elapsed_cycles,
  output logic [7:0]  reg_a,
  output logic [7:0]  reg_b,
  output logic [7:0]  reg_c,
  output logic [7:0]  reg_h,
  output logic [7:0]  reg_l,
  output logic [3:0]  flag_bits
);

  ecpu_pkg::decoded_t    decoded;
  ecpu_pkg::queue_head_t head;
  logic                  full;
  logic                  pop;

  assign in_stall = full;

  // Decode incoming item
  ecpu_front u_front (
    .opcode   (opcode),
    .imm_low  (imm_low),
    .imm_high (imm_high),
    .decoded  (decoded)
  );

  // Buffer decoded items
  ecpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (decoded),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  // Execute and deliver results
  ecpu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_valid    (write_valid),
    .write_address  (write_address),
    .write_data     (write_data),
    .last           (last),
    .next_pc        (next_pc),
    .elapsed_cycles (elapsed_cycles),
    .reg_a          (reg_a),
    .reg_b          (reg_b),
    .reg_c          (reg_c),
    .reg_h          (reg_h),
    .reg_l          (reg_l),
    .flag_bits      (flag_bits)
  );

endmodule
